FILE: rtl/hsvc_pkg.sv
package hsvc_pkg;

  localparam int unsigned NUM_CLASSES          = 3;
  localparam int unsigned CHAN_W               = 8;
  localparam int unsigned BOUND_W              = 24;
  localparam int unsigned DIV_W                = 8;
  localparam int unsigned COUNT_OUT_W          = 18;
  localparam int unsigned CFG_IDX_W            = 3;
  localparam int unsigned QUEUE_DEPTH          = 2;
  localparam int unsigned MAX_FRAME_PIXELS_DEF = 131072;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RED_LO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_HI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_HI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_DIV = 3'd6;

  // Reset values of the bounds: hue<<16 | sat<<8 | val
  localparam logic [BOUND_W-1:0] RST_RED_LO    = 24'hA57658;
  localparam logic [BOUND_W-1:0] RST_RED_HI    = 24'hB4FFFF;
  localparam logic [BOUND_W-1:0] RST_YELLOW_LO = 24'h0E6B81;
  localparam logic [BOUND_W-1:0] RST_YELLOW_HI = 24'h24BCFF;
  localparam logic [BOUND_W-1:0] RST_GREEN_LO  = 24'h372A24;
  localparam logic [BOUND_W-1:0] RST_GREEN_HI  = 24'h51AC50;
  localparam logic [DIV_W-1:0]   RST_RATIO_DIV = 8'd10;

  typedef enum logic [1:0] {
    CLS_RED     = 2'd0,
    CLS_YELLOW  = 2'd1,
    CLS_GREEN   = 2'd2,
    CLS_UNKNOWN = 2'd3
  } color_class_e;

  // One classified pixel as it travels from front to back
  typedef struct packed {
    logic [NUM_CLASSES-1:0] match;
    logic                   last;
  } pix_item_t;

endpackage

FILE: rtl/hsvc_front.sv
module hsvc_front (
  input  logic                                                   in_valid_i,
  output logic                                                   in_ready_o,
  input  logic [hsvc_pkg::CHAN_W-1:0]                            pixel_hue_i,
  input  logic [hsvc_pkg::CHAN_W-1:0]                            pixel_sat_i,
  input  logic [hsvc_pkg::CHAN_W-1:0]                            pixel_val_i,
  input  logic                                                   last_pixel_i,
  input  logic [hsvc_pkg::NUM_CLASSES-1:0][hsvc_pkg::BOUND_W-1:0] bound_lo_i,
  input  logic [hsvc_pkg::NUM_CLASSES-1:0][hsvc_pkg::BOUND_W-1:0] bound_hi_i,
  output logic                                                   push_valid_o,
  input  logic                                                   push_ready_i,
  output hsvc_pkg::pix_item_t                                    push_item_o
);
  import hsvc_pkg::*;

  logic [BOUND_W-1:0] px;

  assign px = {pixel_hue_i, pixel_sat_i, pixel_val_i};

  // Each channel must lie inside [lo, hi]; an inverted range matches nothing
  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      push_item_o.match[k] =
        (px[23:16] >= bound_lo_i[k][23:16]) && (px[23:16] <= bound_hi_i[k][23:16]) &&
        (px[15:8]  >= bound_lo_i[k][15:8])  && (px[15:8]  <= bound_hi_i[k][15:8])  &&
        (px[7:0]   >= bound_lo_i[k][7:0])   && (px[7:0]   <= bound_hi_i[k][7:0]);
    end
    push_item_o.last = last_pixel_i;
  end

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

endmodule

FILE: rtl/hsvc_queue.sv
module hsvc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  hsvc_pkg::pix_item_t push_item_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output hsvc_pkg::pix_item_t pop_item_o
);
  import hsvc_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pix_item_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]       fill_q;
  logic                   push, pop;

  assign push_ready_o = (fill_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (push && !pop)      fill_q <= fill_q + CNT_W'(1);
      else if (pop && !push) fill_q <= fill_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_item_i;
  end

endmodule

FILE: rtl/hsvc_back.sv
module hsvc_back #(
  parameter int unsigned MaxFramePixels = hsvc_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             pop_valid_i,
  output logic                             pop_ready_o,
  input  hsvc_pkg::pix_item_t              pop_item_i,
  input  logic [hsvc_pkg::DIV_W-1:0]       ratio_divisor_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       color_class_o,
  output logic [hsvc_pkg::COUNT_OUT_W-1:0] winning_count_o
);
  import hsvc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MaxFramePixels + 1);
  localparam int unsigned PROD_W = CNT_W + DIV_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MaxFramePixels);

  // Running counters
  logic [CNT_W-1:0]                  total_q, total_d;
  logic [NUM_CLASSES-1:0][CNT_W-1:0] cnt_q, cnt_d;

  // Stage 1: frame snapshot
  logic                              s1_valid_q;
  logic [CNT_W-1:0]                  s1_total_q;
  logic [NUM_CLASSES-1:0][CNT_W-1:0] s1_cnt_q;

  // Stage 2: ratio products
  logic                               s2_valid_q;
  logic [PROD_W-1:0]                  s2_total_q;
  logic [NUM_CLASSES-1:0][PROD_W-1:0] s2_prod_q;
  logic [NUM_CLASSES-1:0][CNT_W-1:0]  s2_cnt_q;

  // Output register
  logic                     out_valid_q;
  color_class_e             out_class_q, out_class_d;
  logic [COUNT_OUT_W-1:0]   out_count_q, out_count_d;

  logic en_out, en_s2, en_s1, pop;
  logic [CNT_W+COUNT_OUT_W-1:0] win_ext;
  logic [CNT_W-1:0]             win_cnt;

  assign en_out      = !out_valid_q || out_ready_i;
  assign en_s2       = !s2_valid_q || en_out;
  assign en_s1       = !s1_valid_q || en_s2;
  assign pop_ready_o = en_s1;
  assign pop         = pop_valid_i && en_s1;

  // Saturating counts including the popped pixel
  always_comb begin
    total_d = (total_q < CNT_MAX) ? total_q + CNT_W'(1) : CNT_MAX;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      cnt_d[k] = (pop_item_i.match[k] && (cnt_q[k] < CNT_MAX)) ?
                 cnt_q[k] + CNT_W'(1) : cnt_q[k];
    end
  end

  // Pick the first class in priority order that passes the ratio test
  always_comb begin
    out_class_d = CLS_UNKNOWN;
    win_cnt     = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (s2_prod_q[k] > s2_total_q) begin
        out_class_d = color_class_e'(k[1:0]);
        win_cnt     = s2_cnt_q[k];
      end
    end
    win_ext     = (CNT_W + COUNT_OUT_W)'(win_cnt);
    out_count_d = win_ext[COUNT_OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        // Clear at frame end; the snapshot carries the final counts
        if (pop_item_i.last) begin
          total_q <= '0;
          cnt_q   <= '0;
        end else begin
          total_q <= total_d;
          cnt_q   <= cnt_d;
        end
      end
      if (en_s1)  s1_valid_q  <= pop && pop_item_i.last;
      if (en_s2)  s2_valid_q  <= s1_valid_q;
      if (en_out) out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s1) begin
      s1_total_q <= total_d;
      s1_cnt_q   <= cnt_d;
    end
    if (en_s2) begin
      s2_total_q <= PROD_W'(s1_total_q);
      s2_cnt_q   <= s1_cnt_q;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        s2_prod_q[k] <= PROD_W'(s1_cnt_q[k]) * PROD_W'(ratio_divisor_i);
      end
    end
    if (en_out) begin
      out_class_q <= out_class_d;
      out_count_q <= out_count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign color_class_o   = out_class_q;
  assign winning_count_o = out_count_q;

endmodule

FILE: rtl/hsv_color_range_classifier.sv
// HSV color range classifier: counts per-class in-range pixels and reports the winner per frame.
// Throughput: one pixel per cycle, limited by the single counter update; output stalls hold it.
// Result path: last pixel via queue, stage 1 snapshot, stage 2 ratio products, output register.
// Reset: counters clear, bounds and ratio divisor return to their defaults, no result pending.
module hsv_color_range_classifier #(
  parameter int unsigned MAX_FRAME_PIXELS = hsvc_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hsvc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [hsvc_pkg::BOUND_W-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [hsvc_pkg::CHAN_W-1:0]      pixel_hue_i,
  input  logic [hsvc_pkg::CHAN_W-1:0]      pixel_sat_i,
  input  logic [hsvc_pkg::CHAN_W-1:0]      pixel_val_i,
  input  logic                             last_pixel_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       color_class_o,
  output logic [hsvc_pkg::COUNT_OUT_W-1:0] winning_count_o
);
  import hsvc_pkg::*;

  logic [NUM_CLASSES-1:0][BOUND_W-1:0] bound_lo_q, bound_hi_q;
  logic [DIV_W-1:0]                    ratio_div_q;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  pix_item_t push_item, pop_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_lo_q  <= {RST_GREEN_LO, RST_YELLOW_LO, RST_RED_LO};
      bound_hi_q  <= {RST_GREEN_HI, RST_YELLOW_HI, RST_RED_HI};
      ratio_div_q <= RST_RATIO_DIV;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RED_LO:    bound_lo_q[0] <= cfg_data_i;
        CFG_RED_HI:    bound_hi_q[0] <= cfg_data_i;
        CFG_YELLOW_LO: bound_lo_q[1] <= cfg_data_i;
        CFG_YELLOW_HI: bound_hi_q[1] <= cfg_data_i;
        CFG_GREEN_LO:  bound_lo_q[2] <= cfg_data_i;
        CFG_GREEN_HI:  bound_hi_q[2] <= cfg_data_i;
        CFG_RATIO_DIV: ratio_div_q   <= cfg_data_i[DIV_W-1:0];
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  hsvc_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_hue_i  (pixel_hue_i),
    .pixel_sat_i  (pixel_sat_i),
    .pixel_val_i  (pixel_val_i),
    .last_pixel_i (last_pixel_i),
    .bound_lo_i   (bound_lo_q),
    .bound_hi_i   (bound_hi_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  hsvc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  hsvc_back #(
    .MaxFramePixels (MAX_FRAME_PIXELS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_item_i      (pop_item),
    .ratio_divisor_i (ratio_div_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .color_class_o   (color_class_o),
    .winning_count_o (winning_count_o)
  );

endmodule

FILE: tb/hsvc_frame_checker.sv
module hsvc_frame_checker #(
  parameter int unsigned MAX_PIX = hsvc_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [hsvc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [hsvc_pkg::BOUND_W-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [hsvc_pkg::CHAN_W-1:0]      pixel_hue_i,
  input  logic [hsvc_pkg::CHAN_W-1:0]      pixel_sat_i,
  input  logic [hsvc_pkg::CHAN_W-1:0]      pixel_val_i,
  input  logic                             last_pixel_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [1:0]                       color_class_i,
  input  logic [hsvc_pkg::COUNT_OUT_W-1:0] winning_count_i,
  output int unsigned                      err_cnt_o,
  output int unsigned                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hsvc_pkg::*;

  localparam color_class_e CLASS_ORDER [NUM_CLASSES] = '{CLS_RED, CLS_YELLOW, CLS_GREEN};

  typedef struct packed {
    color_class_e             cls;
    logic [COUNT_OUT_W-1:0]   cnt;
  } verdict_t;

  verdict_t             verdict_q[$];
  verdict_t             want;
  logic [BOUND_W-1:0]   lo_r [NUM_CLASSES];
  logic [BOUND_W-1:0]   hi_r [NUM_CLASSES];
  logic [DIV_W-1:0]     div_r;
  logic [31:0]          pix_total;
  logic [31:0]          hits [NUM_CLASSES];
  logic [BOUND_W-1:0]   px;
  logic                 found;

  function automatic logic [31:0] bump(logic [31:0] c);
    return (c < MAX_PIX) ? c + 1 : MAX_PIX;
  endfunction

  function automatic logic in_box(logic [BOUND_W-1:0] p, logic [BOUND_W-1:0] lo,
                                  logic [BOUND_W-1:0] hi);
    logic ok;
    ok = 1'b1;
    for (int c = 0; c < 3; c++) begin
      if (p[CHAN_W*c +: CHAN_W] < lo[CHAN_W*c +: CHAN_W] ||
          p[CHAN_W*c +: CHAN_W] > hi[CHAN_W*c +: CHAN_W]) ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic report(string what);
    err_cnt_o++;
    if (err_cnt_o <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verdict_q.delete();
      lo_r[0] = RST_RED_LO;
      hi_r[0] = RST_RED_HI;
      lo_r[1] = RST_YELLOW_LO;
      hi_r[1] = RST_YELLOW_HI;
      lo_r[2] = RST_GREEN_LO;
      hi_r[2] = RST_GREEN_HI;
      div_r = RST_RATIO_DIV;
      pix_total = '0;
      for (int k = 0; k < NUM_CLASSES; k++) hits[k] = '0;
      err_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          report($sformatf("unexpected result: class %0d count %0d",
                           color_class_i, winning_count_i));
        end else begin
          want = verdict_q.pop_front();
          if (want.cls !== color_class_i)
            report($sformatf("color_class: expected %0d, got %0d (count exp %0d got %0d)",
                             want.cls, color_class_i, want.cnt, winning_count_i));
          else if (want.cnt !== winning_count_i)
            report($sformatf("winning_count: expected %0d, got %0d (class %0d)",
                             want.cnt, winning_count_i, color_class_i));
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_RED_LO:    lo_r[0] = cfg_data_i;
          CFG_RED_HI:    hi_r[0] = cfg_data_i;
          CFG_YELLOW_LO: lo_r[1] = cfg_data_i;
          CFG_YELLOW_HI: hi_r[1] = cfg_data_i;
          CFG_GREEN_LO:  lo_r[2] = cfg_data_i;
          CFG_GREEN_HI:  hi_r[2] = cfg_data_i;
          CFG_RATIO_DIV: div_r = cfg_data_i[DIV_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        px = {pixel_hue_i, pixel_sat_i, pixel_val_i};
        pix_total = bump(pix_total);
        for (int k = 0; k < NUM_CLASSES; k++) begin
          if (in_box(px, lo_r[k], hi_r[k])) hits[k] = bump(hits[k]);
        end
        if (last_pixel_i) begin
          // first class in priority order whose share beats 1/divisor
          want.cls = CLS_UNKNOWN;
          want.cnt = '0;
          found = 1'b0;
          for (int k = 0; k < NUM_CLASSES; k++) begin
            if (!found && 64'(hits[k]) * 64'(div_r) > 64'(pix_total)) begin
              want.cls = CLASS_ORDER[k];
              want.cnt = hits[k][COUNT_OUT_W-1:0];
              found = 1'b1;
            end
          end
          verdict_q.insert(verdict_q.size(), want);
          pix_total = '0;
          for (int k = 0; k < NUM_CLASSES; k++) hits[k] = '0;
        end
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hsvc_pkg::*;

  localparam int unsigned MAX_PIX = MAX_FRAME_PIXELS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned RAND_PHASES = 9;
  localparam int unsigned PHASE_PIXELS = 120;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [BOUND_W-1:0]     cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [CHAN_W-1:0]      pixel_hue_i = '0;
  logic [CHAN_W-1:0]      pixel_sat_i = '0;
  logic [CHAN_W-1:0]      pixel_val_i = '0;
  logic                   last_pixel_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [1:0]             color_class_o;
  logic [COUNT_OUT_W-1:0] winning_count_o;

  int unsigned err_cnt;
  int unsigned pending_cnt;

  // stimulus-side view of the settings, written to the DUT and used to aim pixels at ranges
  logic [BOUND_W-1:0] lo_set [NUM_CLASSES];
  logic [BOUND_W-1:0] hi_set [NUM_CLASSES];
  logic [DIV_W-1:0]   div_set;

  int unsigned burst_left = 0;
  int unsigned gap_max = 0;
  int unsigned recv_mode = 0;
  int unsigned recv_tick = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned pix_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned settings_used = 1;

  always #2 clk_i = ~clk_i;

  hsv_color_range_classifier #(
    .MAX_FRAME_PIXELS(MAX_PIX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_hue_i    (pixel_hue_i),
    .pixel_sat_i    (pixel_sat_i),
    .pixel_val_i    (pixel_val_i),
    .last_pixel_i   (last_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .color_class_o  (color_class_o),
    .winning_count_o(winning_count_o)
  );

  hsvc_frame_checker #(
    .MAX_PIX(MAX_PIX)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .pixel_hue_i    (pixel_hue_i),
    .pixel_sat_i    (pixel_sat_i),
    .pixel_val_i    (pixel_val_i),
    .last_pixel_i   (last_pixel_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .color_class_i  (color_class_o),
    .winning_count_i(winning_count_o),
    .err_cnt_o      (err_cnt),
    .pending_o      (pending_cnt)
  );

  // receiver back-pressure, one of several patterns per phase
  always @(posedge clk_i) begin
    recv_tick++;
    case (recv_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= (recv_tick % 7) >= 3;
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 15);
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no beat for %0d cycles, %0d results outstanding",
               $realtime, idle_cycles, pending_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [CHAN_W-1:0] pick_chan(logic [CHAN_W-1:0] lo, logic [CHAN_W-1:0] hi);
    int unsigned m;
    m = $urandom_range(0, 9);
    if (lo > hi || m < 2) return CHAN_W'($urandom_range(0, 255));
    if (m < 6) return CHAN_W'($urandom_range(hi, lo));
    case (m)
      6: return lo;
      7: return hi;
      8: return lo - 1'b1;
      default: return hi + 1'b1;
    endcase
  endfunction

  task automatic send_pixel(input logic [BOUND_W-1:0] px, input logic last);
    int unsigned gap;
    logic acc;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    pixel_hue_i  <= px[23:16];
    pixel_sat_i  <= px[15:8];
    pixel_val_i  <= px[7:0];
    last_pixel_i <= last;
    do begin
      @(negedge clk_i);
      acc = (in_ready_o === 1'b1);
      @(posedge clk_i);
    end while (!acc);
    pix_sent++;
    if (last) frames_sent++;
  endtask

  task automatic send_frame(input int unsigned len, input int unsigned dom);
    int unsigned k;
    logic [BOUND_W-1:0] px;
    for (int unsigned i = 0; i < len; i++) begin
      k = ($urandom_range(0, 3) != 0) ? dom : $urandom_range(0, NUM_CLASSES - 1);
      for (int c = 0; c < 3; c++)
        px[CHAN_W*c +: CHAN_W] = pick_chan(lo_set[k][CHAN_W*c +: CHAN_W],
                                           hi_set[k][CHAN_W*c +: CHAN_W]);
      send_pixel(px, i == len - 1);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] data);
    logic acc;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      acc = (cfg_ready_o === 1'b1);
      @(posedge clk_i);
    end while (!acc);
    cfg_writes++;
  endtask

  task automatic apply_config();
    logic [15:0] junk;
    // upper bits of the divisor write are don't-care; toggle them now and then
    junk = ($urandom_range(0, 1) != 0) ? 16'($urandom()) : '0;
    cfg_write(CFG_RED_LO, lo_set[0]);
    cfg_write(CFG_RED_HI, hi_set[0]);
    cfg_write(CFG_YELLOW_LO, lo_set[1]);
    cfg_write(CFG_YELLOW_HI, hi_set[1]);
    cfg_write(CFG_GREEN_LO, lo_set[2]);
    cfg_write(CFG_GREEN_HI, hi_set[2]);
    cfg_write(CFG_RATIO_DIV, {junk, div_set});
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic rand_config();
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] b;
    int unsigned m;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      for (int c = 0; c < 3; c++) begin
        a = CHAN_W'($urandom_range(0, 255));
        b = CHAN_W'($urandom_range(0, 255));
        m = $urandom_range(0, 9);
        if (m == 0) begin
          lo_set[k][CHAN_W*c +: CHAN_W] = '0;
          hi_set[k][CHAN_W*c +: CHAN_W] = '1;
        end else if (m == 1) begin
          lo_set[k][CHAN_W*c +: CHAN_W] = (a > b) ? a : b;
          hi_set[k][CHAN_W*c +: CHAN_W] = (a > b) ? b : a;
        end else begin
          lo_set[k][CHAN_W*c +: CHAN_W] = (a > b) ? b : a;
          hi_set[k][CHAN_W*c +: CHAN_W] = (a > b) ? a : b;
        end
      end
    end
    case ($urandom_range(0, 4))
      0: div_set = 8'd1;
      1: div_set = DIV_W'($urandom_range(2, 4));
      2: div_set = DIV_W'($urandom_range(5, 20));
      3: div_set = DIV_W'($urandom_range(1, 255));
      default: div_set = 8'd255;
    endcase
  endtask

  // drain all results, then let the pipeline settle before touching registers
  task automatic wait_idle();
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic end_phase();
    in_valid_i <= 1'b0;
    burst_left = 0;
    wait_idle();
    gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    recv_mode = $urandom_range(0, 3);
  endtask

  initial begin
    int unsigned phase_px;
    int unsigned len;

    lo_set[0] = RST_RED_LO;
    hi_set[0] = RST_RED_HI;
    lo_set[1] = RST_YELLOW_LO;
    hi_set[1] = RST_YELLOW_HI;
    lo_set[2] = RST_GREEN_LO;
    hi_set[2] = RST_GREEN_HI;
    div_set   = RST_RATIO_DIV;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames on the default ranges
    gap_max = 3;
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(RST_RED_LO, 1'b1);
    send_pixel(RST_RED_HI, 1'b1);
    send_pixel(RST_YELLOW_LO, 1'b1);
    send_pixel(RST_YELLOW_HI, 1'b1);
    send_pixel(RST_GREEN_LO, 1'b1);
    send_pixel(RST_GREEN_HI, 1'b1);
    // one red in ten: exactly at the ratio, must not qualify
    send_pixel(RST_RED_LO, 1'b0);
    for (int i = 0; i < 9; i++) send_pixel(24'h000000, i == 8);
    // one yellow in nine: just past the ratio
    send_pixel(RST_YELLOW_HI, 1'b0);
    for (int i = 0; i < 8; i++) send_pixel(24'h000000, i == 7);
    end_phase();

    // every range full, widest divisor: red always wins
    for (int k = 0; k < NUM_CLASSES; k++) begin
      lo_set[k] = '0;
      hi_set[k] = '1;
    end
    div_set = 8'd255;
    cfg_write(CFG_SPARE, BOUND_W'($urandom()));
    apply_config();
    for (int f = 0; f < 4; f++) send_frame($urandom_range(1, 6), $urandom_range(0, 2));
    end_phase();

    // every range full, divisor one: nothing can exceed the total
    div_set = 8'd1;
    apply_config();
    for (int f = 0; f < 4; f++) send_frame($urandom_range(1, 6), $urandom_range(0, 2));
    end_phase();

    // inverted ranges, with zero divisor and then with divisor 255
    lo_set[0] = 24'hFF0000;
    hi_set[0] = 24'h00FFFF;
    lo_set[1] = 24'h00FF00;
    hi_set[1] = 24'hFF00FF;
    lo_set[2] = 24'h0000FF;
    hi_set[2] = 24'hFFFF00;
    div_set   = 8'd0;
    apply_config();
    for (int f = 0; f < 3; f++) send_frame($urandom_range(1, 6), $urandom_range(0, 2));
    end_phase();
    div_set = 8'd255;
    apply_config();
    for (int f = 0; f < 3; f++) send_frame($urandom_range(1, 6), $urandom_range(0, 2));
    end_phase();

    for (int p = 0; p < RAND_PHASES; p++) begin
      rand_config();
      apply_config();
      phase_px = 0;
      while (phase_px < PHASE_PIXELS) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 30);
        send_frame(len, $urandom_range(0, 2));
        phase_px += len;
      end
      end_phase();
    end

    repeat (4) @(posedge clk_i);

    $display("Sent %0d pixels in %0d frames under %0d register settings (%0d writes).",
             pix_sent, frames_sent, settings_used, cfg_writes);
    $display("Ranges full, empty and random; divisor 0 to 255; frames of 1 to 200 pixels.");
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/hsvc_pkg.sv
rtl/hsvc_front.sv
rtl/hsvc_queue.sv
rtl/hsvc_back.sv
rtl/hsv_color_range_classifier.sv
tb/hsvc_frame_checker.sv
tb/tb_top.sv
